// ----- hdl/bsfb_pkg.sv -----
// bsfb_pkg: shared constants and types for the byte stuffed frame builder
// no dependencies; imported by bsfb_seq, bsfb_stuff and byte_stuffed_frame_builder
package bsfb_pkg;

  localparam int unsigned PAYLOAD_BYTES = 4;
  localparam int unsigned PAY_W         = 8 * PAYLOAD_BYTES;
  localparam int unsigned CNT_W         = $clog2(PAYLOAD_BYTES + 1);

  localparam logic [7:0] ESC_BYTE   = 8'h7D;
  localparam logic [7:0] ESC_XOR    = 8'h20;
  localparam logic [7:0] ADDR_CMD   = 8'h03;
  localparam logic [7:0] ADDR_REPLY = 8'h01;
  localparam logic [7:0] FLAG_RESET = 8'h7E;

  localparam logic OP_SUPERVISORY = 1'b0;
  localparam logic OP_INFORMATION = 1'b1;

  // one unstuffed frame byte handed from the sequencer to the stuffer
  typedef struct packed {
    logic [7:0] data;
    logic       stuff;
    logic       last;
  } raw_byte_t;

endpackage

// ----- hdl/bsfb_seq.sv -----
// bsfb_seq: frame sequencer, walks the frame fields and produces raw bytes
// one per handoff; payload bytes come out of a shared shift/xor unit
// depends on bsfb_pkg
module bsfb_seq
  import bsfb_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [7:0]       flag_i,
  input  logic             req_valid_i,
  output logic             req_ready_o,
  input  logic             op_i,
  input  logic             reply_address_i,
  input  logic [7:0]       control_byte_i,
  input  logic [31:0]      payload_i,
  output logic             raw_valid_o,
  input  logic             raw_ready_i,
  output raw_byte_t        raw_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_FLAG_OPEN,
    S_ADDR,
    S_CTRL,
    S_HCS,
    S_PAY,
    S_CHECK,
    S_FLAG_CLOSE
  } state_e;

  state_e           state_q, state_d;
  logic             op_q, op_d;
  logic [7:0]       addr_q, addr_d;
  logic [7:0]       ctrl_q, ctrl_d;
  logic [PAY_W-1:0] shift_q, shift_d;
  logic [7:0]       check_q, check_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [63:0]      pay_ext;
  logic             step;

  assign pay_ext     = 64'(payload_i);
  assign req_ready_o = (state_q == S_IDLE);
  assign raw_valid_o = (state_q != S_IDLE);
  assign step        = raw_valid_o && raw_ready_i;

  always_comb begin
    raw_o.stuff = (op_q == OP_INFORMATION);
    raw_o.last  = 1'b0;
    case (state_q)
      S_FLAG_OPEN: begin
        raw_o.data  = flag_i;
        raw_o.stuff = 1'b0;
      end
      S_ADDR:  raw_o.data = addr_q;
      S_CTRL:  raw_o.data = ctrl_q;
      S_HCS:   raw_o.data = addr_q ^ ctrl_q;
      S_PAY:   raw_o.data = shift_q[7:0];
      S_CHECK: raw_o.data = check_q;
      S_FLAG_CLOSE: begin
        raw_o.data  = flag_i;
        raw_o.stuff = 1'b0;
        raw_o.last  = 1'b1;
      end
      default: begin
        raw_o.data  = 8'h00;
        raw_o.stuff = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    addr_d  = addr_q;
    ctrl_d  = ctrl_q;
    shift_d = shift_q;
    check_d = check_q;
    cnt_d   = cnt_q;
    case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          op_d    = op_i;
          ctrl_d  = control_byte_i;
          addr_d  = (op_i == OP_SUPERVISORY && reply_address_i) ? ADDR_REPLY : ADDR_CMD;
          shift_d = pay_ext[PAY_W-1:0];
          check_d = 8'h00;
          cnt_d   = '0;
          state_d = S_FLAG_OPEN;
        end
      end
      S_FLAG_OPEN: if (step) state_d = S_ADDR;
      S_ADDR:      if (step) state_d = S_CTRL;
      S_CTRL:      if (step) state_d = S_HCS;
      S_HCS: begin
        if (step) state_d = (op_q == OP_INFORMATION) ? S_PAY : S_FLAG_CLOSE;
      end
      S_PAY: begin
        // shared unit: shift out one payload byte and fold it into the check
        if (step) begin
          shift_d = shift_q >> 8;
          check_d = check_q ^ shift_q[7:0];
          cnt_d   = cnt_q + 1'b1;
          if (cnt_q == CNT_W'(PAYLOAD_BYTES - 1)) state_d = S_CHECK;
        end
      end
      S_CHECK:      if (step) state_d = S_FLAG_CLOSE;
      S_FLAG_CLOSE: if (step) state_d = S_IDLE;
      default:      state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q    <= op_d;
    addr_q  <= addr_d;
    ctrl_q  <= ctrl_d;
    shift_q <= shift_d;
    check_q <= check_d;
    cnt_q   <= cnt_d;
  end

endmodule

// ----- hdl/bsfb_stuff.sv -----
// bsfb_stuff: escape stuffing and output register
// splits an escaped byte into two line bytes; depends on bsfb_pkg
module bsfb_stuff
  import bsfb_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [7:0] flag_i,
  input  logic       raw_valid_i,
  output logic       raw_ready_o,
  input  raw_byte_t  raw_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       out_last_o
);

  logic       valid_q, valid_d;
  logic       pend_q, pend_d;
  logic [7:0] pend_byte_q, pend_byte_d;
  logic [7:0] byte_q, byte_d;
  logic       last_q, last_d;
  logic       load;
  logic       hit;

  assign load        = !valid_q || out_ready_i;
  assign raw_ready_o = load && !pend_q;
  assign hit         = raw_i.stuff && (raw_i.data == ESC_BYTE || raw_i.data == flag_i);

  always_comb begin
    valid_d     = valid_q;
    pend_d      = pend_q;
    pend_byte_d = pend_byte_q;
    byte_d      = byte_q;
    last_d      = last_q;
    if (load) begin
      if (pend_q) begin
        // second half of an escape pair, never the closing flag
        valid_d = 1'b1;
        pend_d  = 1'b0;
        byte_d  = pend_byte_q;
        last_d  = 1'b0;
      end else if (raw_valid_i) begin
        valid_d = 1'b1;
        if (hit) begin
          byte_d      = ESC_BYTE;
          last_d      = 1'b0;
          pend_d      = 1'b1;
          pend_byte_d = raw_i.data ^ ESC_XOR;
        end else begin
          byte_d = raw_i.data;
          last_d = raw_i.last;
        end
      end else begin
        valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      pend_q  <= 1'b0;
    end else begin
      valid_q <= valid_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_byte_q <= pend_byte_d;
    byte_q      <= byte_d;
    last_q      <= last_d;
  end

  assign out_valid_o = valid_q;
  assign out_byte_o  = byte_q;
  assign out_last_o  = last_q;

endmodule

// ----- hdl/byte_stuffed_frame_builder.sv -----
// byte_stuffed_frame_builder: top level, flag register, sequencer and stuffer
// depends on bsfb_pkg, bsfb_seq, bsfb_stuff
//
// channel   dir  signals                        content
// s_axis    in   tvalid tready tdata tuser      one frame request
// m_axis    out  tvalid tready tdata tlast      one line byte, tlast on closing flag
// cfg       in   cfg_we_i cfg_wdata_i           flag byte register
//
// within a frame one line byte leaves per cycle when m_axis is not stalled; a
// supervisory frame carries the flags, address, control and HCS bytes, and an
// information frame adds PAYLOAD_BYTES payload bytes and a check byte; the sequencer
// waits while an escape pair's second byte leaves; an idle state takes each request.
// a new request is taken the cycle after the closing flag has entered the output register.
// reset clears the control state and sets the flag byte to 0x7e.
// an m_axis stall holds the output register and freezes the sequencer.
module byte_stuffed_frame_builder
  import bsfb_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // control_byte [7:0], payload [39:8]
  input  logic [1:0]  s_axis_tuser,   // op [0], reply_address [1]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // out_byte [7:0]
  output logic        m_axis_tlast
);

  logic [7:0] flag_q;
  logic       raw_valid;
  logic       raw_ready;
  raw_byte_t  raw;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flag_q <= FLAG_RESET;
    end else if (cfg_we_i) begin
      flag_q <= cfg_wdata_i;
    end
  end

  bsfb_seq u_seq (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .flag_i          (flag_q),
    .req_valid_i     (s_axis_tvalid),
    .req_ready_o     (s_axis_tready),
    .op_i            (s_axis_tuser[0]),
    .reply_address_i (s_axis_tuser[1]),
    .control_byte_i  (s_axis_tdata[7:0]),
    .payload_i       (s_axis_tdata[39:8]),
    .raw_valid_o     (raw_valid),
    .raw_ready_i     (raw_ready),
    .raw_o           (raw)
  );

  bsfb_stuff u_stuff (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .flag_i      (flag_q),
    .raw_valid_i (raw_valid),
    .raw_ready_o (raw_ready),
    .raw_i       (raw),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_byte_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

endmodule
